// File: hdl/tfe_pkg.sv
// Shared types, constants and name tables for the time format expander.
`default_nettype none
package tfe_pkg;

  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned TEXT_W   = 72;  // nine characters, first one in the top byte
  localparam int unsigned MAX_DIG  = 5;

  localparam logic [ADDR_W-3:0] REG_CAPACITY = 1'b0;  // word index of the capacity register

  localparam logic [7:0] CAPACITY_RESET = 8'd96;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_SP   = 8'h20;

  // Reciprocal of ten for values below 2**14: q = (x * RECIP10) >> RECIP10_SH
  localparam logic [16:0] RECIP10    = 17'd52429;
  localparam int unsigned RECIP10_SH = 19;

  typedef struct packed {
    logic [7:0]  fmt_char;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [13:0] year_number;
    logic [2:0]  weekday_number;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_t;

  // One unit of work for the back end: either preformatted text or a number
  // still to be converted to decimal.
  typedef struct packed {
    logic              is_num;
    logic              last;
    logic [3:0]        count;   // characters to emit
    logic [2:0]        ndig;    // digits to convert for a number
    logic [13:0]       value;
    logic [TEXT_W-1:0] text;
  } cmd_t;

  function automatic logic [TEXT_W-1:0] day_abbr_word(input logic [2:0] wday);
    logic [TEXT_W-1:0] w;
    unique case (wday)
      3'd1:    w = {"Mon", {6{CH_SP}}};
      3'd2:    w = {"Tue", {6{CH_SP}}};
      3'd3:    w = {"Wed", {6{CH_SP}}};
      3'd4:    w = {"Thu", {6{CH_SP}}};
      3'd5:    w = {"Fri", {6{CH_SP}}};
      3'd6:    w = {"Sat", {6{CH_SP}}};
      default: w = {"Sun", {6{CH_SP}}};
    endcase
    return w;
  endfunction

  function automatic logic [TEXT_W-1:0] day_full_word(input logic [2:0] wday);
    logic [TEXT_W-1:0] w;
    unique case (wday)
      3'd1:    w = {"Monday", {3{CH_SP}}};
      3'd2:    w = {"Tuesday", {2{CH_SP}}};
      3'd3:    w = "Wednesday";
      3'd4:    w = {"Thursday", CH_SP};
      3'd5:    w = {"Friday", {3{CH_SP}}};
      3'd6:    w = {"Saturday", CH_SP};
      default: w = {"Sunday", {3{CH_SP}}};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] day_full_len(input logic [2:0] wday);
    logic [3:0] n;
    unique case (wday)
      3'd2:         n = 4'd7;
      3'd3:         n = 4'd9;
      3'd4, 3'd6:   n = 4'd8;
      default:      n = 4'd6;
    endcase
    return n;
  endfunction

  function automatic logic [TEXT_W-1:0] mon_abbr_word(input logic [3:0] midx);
    logic [TEXT_W-1:0] w;
    unique case (midx)
      4'd1:    w = {"Feb", {6{CH_SP}}};
      4'd2:    w = {"Mar", {6{CH_SP}}};
      4'd3:    w = {"Apr", {6{CH_SP}}};
      4'd4:    w = {"May", {6{CH_SP}}};
      4'd5:    w = {"Jun", {6{CH_SP}}};
      4'd6:    w = {"Jul", {6{CH_SP}}};
      4'd7:    w = {"Aug", {6{CH_SP}}};
      4'd8:    w = {"Sep", {6{CH_SP}}};
      4'd9:    w = {"Oct", {6{CH_SP}}};
      4'd10:   w = {"Nov", {6{CH_SP}}};
      4'd11:   w = {"Dec", {6{CH_SP}}};
      default: w = {"Jan", {6{CH_SP}}};
    endcase
    return w;
  endfunction

  function automatic logic [TEXT_W-1:0] mon_full_word(input logic [3:0] midx);
    logic [TEXT_W-1:0] w;
    unique case (midx)
      4'd1:    w = {"February", CH_SP};
      4'd2:    w = {"March", {4{CH_SP}}};
      4'd3:    w = {"April", {4{CH_SP}}};
      4'd4:    w = {"May", {6{CH_SP}}};
      4'd5:    w = {"June", {5{CH_SP}}};
      4'd6:    w = {"July", {5{CH_SP}}};
      4'd7:    w = {"August", {3{CH_SP}}};
      4'd8:    w = "September";
      4'd9:    w = {"October", {2{CH_SP}}};
      4'd10:   w = {"November", CH_SP};
      4'd11:   w = {"December", CH_SP};
      default: w = {"January", {2{CH_SP}}};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] mon_full_len(input logic [3:0] midx);
    logic [3:0] n;
    unique case (midx)
      4'd1, 4'd10, 4'd11: n = 4'd8;
      4'd2, 4'd3:         n = 4'd5;
      4'd4:               n = 4'd3;
      4'd5, 4'd6:         n = 4'd4;
      4'd7:               n = 4'd6;
      4'd8:               n = 4'd9;
      default:            n = 4'd7;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// File: hdl/tfe_front.sv
// Front end: takes format characters, tracks the pending '%' and the fill level,
// and turns format characters and selectors into commands for the back end.
`default_nettype none
module tfe_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    capacity,
  input  wire logic          push,
  input  wire tfe_pkg::in_t  item,
  output logic               cmd_push,
  output tfe_pkg::cmd_t      cmd,
  input  wire logic          cmd_full
);

  localparam logic [7:0] SPEC_H   = "H";
  localparam logic [7:0] SPEC_K   = "k";
  localparam logic [7:0] SPEC_M   = "M";
  localparam logic [7:0] SPEC_S   = "S";
  localparam logic [7:0] SPEC_D   = "d";
  localparam logic [7:0] SPEC_E   = "e";
  localparam logic [7:0] SPEC_MON = "m";
  localparam logic [7:0] SPEC_Y4  = "Y";
  localparam logic [7:0] SPEC_Y2  = "y";
  localparam logic [7:0] SPEC_A   = "a";
  localparam logic [7:0] SPEC_AF  = "A";
  localparam logic [7:0] SPEC_B   = "b";
  localparam logic [7:0] SPEC_BF  = "B";
  localparam logic [7:0] SPEC_I   = "I";
  localparam logic [7:0] SPEC_L   = "l";
  localparam logic [7:0] SPEC_P   = "p";
  localparam logic [7:0] SPEC_PL  = "P";

  logic       pending, pending_next;
  logic [7:0] chars_written, chars_written_next;

  logic            accept;
  logic            buf_full;
  logic            fits_two;
  logic [7:0]      room;
  logic [4:0]      hr_mod;
  logic [3:0]      hr12;
  logic            hr_pm;
  logic [3:0]      midx;
  logic [3:0]      len;
  logic [3:0]      n;
  tfe_pkg::cmd_t   spec;

  assign accept   = push && !cmd_full;
  assign buf_full = ({1'b0, chars_written} + 9'd1) >= {1'b0, capacity};
  assign fits_two = ({1'b0, chars_written} + 9'd2) <  {1'b0, capacity};
  assign room     = capacity - chars_written - 8'd1;

  always_comb begin
    if (item.hour >= 5'd24) begin
      hr_mod = item.hour - 5'd24;
    end else if (item.hour >= 5'd12) begin
      hr_mod = item.hour - 5'd12;
    end else begin
      hr_mod = item.hour;
    end
    hr12  = (hr_mod == 5'd0) ? 4'd12 : hr_mod[3:0];
    hr_pm = item.hour >= 5'd12;
    midx  = (item.month_number >= 4'd1 && item.month_number <= 4'd12) ?
            item.month_number - 4'd1 : 4'd0;
  end

  // Decode the selector after a '%' into a command and its full length.
  always_comb begin
    spec = '0;
    len  = 4'd0;
    unique case (item.fmt_char)
      SPEC_H: begin
        spec.is_num = 1'b1; spec.value = 14'(item.hour); spec.ndig = 3'd2;
      end
      SPEC_K: begin
        spec.is_num = 1'b1; spec.value = 14'(item.hour);
        spec.ndig = (item.hour >= 5'd10) ? 3'd2 : 3'd1;
      end
      SPEC_M: begin
        spec.is_num = 1'b1; spec.value = 14'(item.minute); spec.ndig = 3'd2;
      end
      SPEC_S: begin
        spec.is_num = 1'b1; spec.value = 14'(item.second); spec.ndig = 3'd2;
      end
      SPEC_D: begin
        spec.is_num = 1'b1; spec.value = 14'(item.day_of_month); spec.ndig = 3'd2;
      end
      SPEC_E: begin
        spec.is_num = 1'b1; spec.value = 14'(item.day_of_month);
        spec.ndig = (item.day_of_month >= 5'd10) ? 3'd2 : 3'd1;
      end
      SPEC_MON: begin
        spec.is_num = 1'b1; spec.value = 14'(item.month_number); spec.ndig = 3'd2;
      end
      SPEC_Y4: begin
        spec.is_num = 1'b1; spec.value = item.year_number;
        spec.ndig = (item.year_number >= 14'd10000) ? 3'd5 : 3'd4;
      end
      SPEC_Y2: begin
        // two low digits of the year are year mod 100
        spec.is_num = 1'b1; spec.value = item.year_number; spec.ndig = 3'd2;
      end
      SPEC_I: begin
        spec.is_num = 1'b1; spec.value = 14'(hr12); spec.ndig = 3'd2;
      end
      SPEC_L: begin
        spec.is_num = 1'b1; spec.value = 14'(hr12);
        spec.ndig = (hr12 >= 4'd10) ? 3'd2 : 3'd1;
      end
      SPEC_A: begin
        spec.text = tfe_pkg::day_abbr_word(item.weekday_number); len = 4'd3;
      end
      SPEC_AF: begin
        spec.text = tfe_pkg::day_full_word(item.weekday_number);
        len = tfe_pkg::day_full_len(item.weekday_number);
      end
      SPEC_B: begin
        spec.text = tfe_pkg::mon_abbr_word(midx); len = 4'd3;
      end
      SPEC_BF: begin
        spec.text = tfe_pkg::mon_full_word(midx); len = tfe_pkg::mon_full_len(midx);
      end
      SPEC_P: begin
        spec.text = hr_pm ? {"PM", {7{tfe_pkg::CH_SP}}} : {"AM", {7{tfe_pkg::CH_SP}}};
        len = 4'd2;
      end
      SPEC_PL: begin
        spec.text = hr_pm ? {"pm", {7{tfe_pkg::CH_SP}}} : {"am", {7{tfe_pkg::CH_SP}}};
        len = 4'd2;
      end
      tfe_pkg::CH_PCT: begin
        spec.text = {tfe_pkg::CH_PCT, 64'd0}; len = 4'd1;
      end
      default: begin
        // unknown selector: echo both characters, or nothing when they do not fit
        spec.text = {tfe_pkg::CH_PCT, item.fmt_char, 56'd0};
        len = fits_two ? 4'd2 : 4'd0;
      end
    endcase
    if (spec.is_num) begin
      len = 4'(spec.ndig);
    end
  end

  always_comb begin
    cmd                = '0;
    cmd_push           = 1'b0;
    pending_next       = pending;
    chars_written_next = chars_written;
    n                  = (room < 8'(len)) ? room[3:0] : len;
    if (accept) begin
      if (item.fmt_char == tfe_pkg::CH_NUL) begin
        cmd.last           = 1'b1;
        cmd.count          = 4'd1;
        cmd_push           = 1'b1;
        pending_next       = 1'b0;
        chars_written_next = 8'd0;
      end else if (!buf_full) begin
        if (!pending) begin
          if (item.fmt_char == tfe_pkg::CH_PCT) begin
            pending_next = 1'b1;
          end else begin
            cmd.text           = {item.fmt_char, 64'd0};
            cmd.count          = 4'd1;
            cmd_push           = 1'b1;
            chars_written_next = chars_written + 8'd1;
          end
        end else begin
          pending_next       = 1'b0;
          cmd                = spec;
          cmd.count          = n;
          cmd_push           = n != 4'd0;
          chars_written_next = chars_written + 8'(n);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= 1'b0;
      chars_written <= 8'd0;
    end else begin
      pending       <= pending_next;
      chars_written <= chars_written_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/tfe_cmd_queue.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none
module tfe_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tfe_pkg::cmd_t din,
  output logic               full,
  input  wire logic          pop,
  output tfe_pkg::cmd_t      dout,
  output logic               empty
);

  tfe_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

// File: hdl/tfe_back.sv
// Back end: converts numbers to decimal and emits one character per cycle
// into a two-entry result queue whenever that queue has room.
`default_nettype none
module tfe_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tfe_pkg::cmd_t cmd,
  input  wire logic          cmd_empty,
  output logic               cmd_pop,
  output tfe_pkg::out_t      result,
  output logic               empty,
  input  wire logic          pop
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_CONV = 3'b010,
    B_EMIT = 3'b100
  } back_state_t;

  back_state_t              state, state_next;
  logic [tfe_pkg::TEXT_W-1:0] sh;
  logic [13:0]              x;
  logic [2:0]               k;
  logic [3:0]               cnt;
  logic [3:0]               cur_n;
  logic [2:0]               cur_nd;
  logic                     cur_last;

  tfe_pkg::out_t            oslots [2];
  logic                     owr, ord;
  logic [1:0]               ocount;
  logic                     ofull;
  logic                     owrite;
  logic                     opop;

  logic [29:0]              prod;
  logic [10:0]              q;
  logic [13:0]              ten_q;
  logic [3:0]               dig;

  // divide by ten through the reciprocal, remainder is the next digit
  assign prod  = 30'(x) * 30'(tfe_pkg::RECIP10);
  assign q     = prod[tfe_pkg::RECIP10_SH +: 11];
  assign ten_q = 14'({q, 3'b000}) + 14'({q, 1'b0});
  assign dig   = 4'(x - ten_q);

  assign ofull   = ocount == 2'd2;
  assign empty   = ocount == 2'd0;
  assign opop    = pop && !empty;
  assign owrite  = (state == B_EMIT) && !ofull;
  assign cmd_pop = (state == B_IDLE) && !cmd_empty;
  assign result  = oslots[ord];

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!cmd_empty) begin
          state_next = cmd.is_num ? B_CONV : B_EMIT;
        end
      end
      B_CONV: begin
        if (k == cur_nd - 3'd1) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (!ofull && cnt == cur_n - 4'd1) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        sh       <= cmd.text;
        x        <= cmd.value;
        k        <= 3'd0;
        cnt      <= 4'd0;
        cur_n    <= cmd.count;
        cur_nd   <= cmd.ndig;
        cur_last <= cmd.last;
      end
      B_CONV: begin
        sh <= {tfe_pkg::CH_ZERO | {4'd0, dig}, sh[tfe_pkg::TEXT_W-1:8]};
        x  <= 14'(q);
        k  <= k + 3'd1;
      end
      B_EMIT: begin
        if (!ofull) begin
          sh  <= {sh[tfe_pkg::TEXT_W-9:0], 8'd0};
          cnt <= cnt + 4'd1;
        end
      end
      default: ;
    endcase
    if (owrite) begin
      oslots[owr] <= '{out_char: sh[tfe_pkg::TEXT_W-1 -: 8], out_last: cur_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      owr    <= 1'b0;
      ord    <= 1'b0;
      ocount <= 2'd0;
    end else begin
      state <= state_next;
      if (owrite) begin
        owr <= ~owr;
      end
      if (opop) begin
        ord <= ~ord;
      end
      ocount <= ocount + {1'b0, owrite} - {1'b0, opop};
    end
  end

endmodule
`default_nettype wire

// File: hdl/time_format_expander_top.sv
// Top level of the time format expander: configuration port, front end,
// command queue and back end.
`default_nettype none
// Expands a strftime-style format string one character per input transaction.
// Push a format character with the current time fields; results come out one
// character per transaction on the result queue, and a NUL input ends the
// string with a NUL result flagged out_last, which also clears the fill count
// and any pending '%'. Supported selectors: %H %k %M %S %d %e %m %Y %y %I %l
// %p %P %a %A %b %B %%; an unknown selector is echoed as '%' plus the
// character only when both fit, and a '%' right before the NUL is dropped.
// Output stops after capacity-1 characters; later non-NUL input is swallowed.
// The capacity register (reset 96) sits at address 0 of the APB port and must
// only be written while the block is idle. Timing: the front end accepts one
// item per cycle while its two-entry command queue has room; push is held off
// only when that queue is full, which happens when the back end falls behind
// or when waiting results stall the back end. The back end loads each command,
// converts a number to decimal one digit at a time through a shared
// divide-by-ten step, and emits the characters one by one, holding while the
// result queue is full. A '%' alone or a swallowed character uses no back-end
// time at all.
module time_format_expander_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tfe_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [tfe_pkg::DATA_W-1:0]  pwdata,
  output logic      [tfe_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  // format characters in
  input  wire logic                        push,
  output logic                             full,
  input  wire tfe_pkg::in_t                item,
  // characters out
  output logic                             empty,
  input  wire logic                        pop,
  output tfe_pkg::out_t                    result
);

  logic [7:0]    capacity;
  logic          cfg_write;
  logic          cmd_push;
  logic          cmd_full;
  logic          cmd_pop;
  logic          cmd_empty;
  tfe_pkg::cmd_t cmd_in;
  tfe_pkg::cmd_t cmd_out;

  // APB: no wait states; the word index picks the register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[tfe_pkg::ADDR_W-1:2] == tfe_pkg::REG_CAPACITY);
  assign prdata    = (paddr[tfe_pkg::ADDR_W-1:2] == tfe_pkg::REG_CAPACITY) ?
                     tfe_pkg::DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= tfe_pkg::CAPACITY_RESET;
    end else if (cfg_write) begin
      capacity <= pwdata[7:0];
    end
  end

  // Full follows the command queue: the front end never stalls on anything else.
  assign full = cmd_full;

  tfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .push     (push),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  tfe_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  tfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
`default_nettype wire
